// File: hdl/ilp_pkg.sv
// Shared constants, suffix table and suffix check for the integer literal parser.
`default_nettype none

package ilp_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int OUT_BITS = 64;
    localparam int CHAR_BITS = 8;
    localparam int SFX_MAX = 3;
    localparam int SFX_ENTRIES = 20;
    // Count value that marks a suffix longer than SFX_MAX
    localparam logic [2:0] SFX_CNT_TOO_LONG = 3'd4;

    localparam logic [CHAR_BITS-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_0 = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_7 = 8'h37;
    localparam logic [CHAR_BITS-1:0] CH_9 = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UA = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UF = 8'h46;
    localparam logic [CHAR_BITS-1:0] CH_UL = 8'h4c;
    localparam logic [CHAR_BITS-1:0] CH_UU = 8'h55;
    localparam logic [CHAR_BITS-1:0] CH_UX = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_LA = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LF = 8'h66;
    localparam logic [CHAR_BITS-1:0] CH_LL = 8'h6c;
    localparam logic [CHAR_BITS-1:0] CH_LU = 8'h75;
    localparam logic [CHAR_BITS-1:0] CH_LX = 8'h78;

    // Suffix characters, first character in element 0
    typedef logic [SFX_MAX-1:0][CHAR_BITS-1:0] sfx_chars_t;

    typedef struct packed {
        logic [1:0] len;
        sfx_chars_t txt;
    } sfx_entry_t;

    localparam sfx_entry_t SFX_TABLE [SFX_ENTRIES] = '{
        '{2'd1, {CH_NUL, CH_NUL, CH_LU}}, '{2'd1, {CH_NUL, CH_NUL, CH_UU}},
        '{2'd1, {CH_NUL, CH_NUL, CH_LL}}, '{2'd1, {CH_NUL, CH_NUL, CH_UL}},
        '{2'd2, {CH_NUL, CH_LL, CH_LU}}, '{2'd2, {CH_NUL, CH_UL, CH_UU}},
        '{2'd2, {CH_NUL, CH_UL, CH_LU}}, '{2'd2, {CH_NUL, CH_LL, CH_UU}},
        '{2'd2, {CH_NUL, CH_LU, CH_LL}}, '{2'd2, {CH_NUL, CH_UU, CH_UL}},
        '{2'd2, {CH_NUL, CH_UU, CH_LL}}, '{2'd2, {CH_NUL, CH_LU, CH_UL}},
        '{2'd3, {CH_LL, CH_LL, CH_LU}}, '{2'd3, {CH_UL, CH_UL, CH_UU}},
        '{2'd3, {CH_UL, CH_UL, CH_LU}}, '{2'd3, {CH_LL, CH_LL, CH_UU}},
        '{2'd3, {CH_LU, CH_LL, CH_LL}}, '{2'd3, {CH_UU, CH_UL, CH_UL}},
        '{2'd3, {CH_UU, CH_LL, CH_LL}}, '{2'd3, {CH_LU, CH_UL, CH_UL}}
    };

    // Empty suffix passes; otherwise it must equal one table entry
    function automatic logic sfx_match(input logic [2:0] cnt, input sfx_chars_t chars);
        logic ok;
        logic eq;
        ok = 1'b0;
        if (cnt == 3'd0)
        begin
            ok = 1'b1;
        end
        else if (cnt <= 3'(SFX_MAX))
        begin
            for (int i = 0; i < SFX_ENTRIES; i++)
            begin
                eq = ({1'b0, SFX_TABLE[i].len} == cnt);
                for (int j = 0; j < SFX_MAX; j++)
                begin
                    if ((3'(j) < cnt) && (SFX_TABLE[i].txt[j] != chars[j]))
                    begin
                        eq = 1'b0;
                    end
                end
                ok = ok | eq;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// File: hdl/integer_literal_parser.sv
// Streaming parser for one C integer literal: digits to value, suffix check.
//
//  channel  | dir | tdata                  | tuser          | tlast
//  s_axis   | in  | [7:0] char_code        | -              | last character
//  m_axis   | out | [63:0] value (signed)  | [0] valid_res  | -
//
// One character per cycle: each accepted item updates the parse state in the
// same cycle, through one shift-add of the accumulator and the suffix compare.
// The item with tlast loads the result register; the result appears in the next cycle.
// A held result stalls input only while m_axis_tready is low.
// rst_n (async, active low) clears the parse state and the result valid.
`default_nettype none

module integer_literal_parser
    import ilp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [CHAR_BITS-1:0] s_axis_tdata,   // [7:0] char_code
    input  wire logic                 s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [OUT_BITS-1:0]       m_axis_tdata,   // [63:0] value
    output logic                      m_axis_tuser    // [0] valid_res
);

    typedef enum logic [2:0] {
        PH_START,
        PH_ZERO,
        PH_HEX,
        PH_OCT,
        PH_DEC,
        PH_SUF
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    sfx_chars_t              sfx_reg, sfx_next;
    logic [2:0]              cnt_reg, cnt_next;
    logic                    out_valid_reg;
    logic [OUT_BITS-1:0]     value_reg, value_next;
    logic                    ok_reg, ok_next;

    logic                    accept;
    logic [CHAR_BITS-1:0]    c;
    logic                    is_dec, is_oct, is_hex_lc, is_hex_uc, is_x;
    logic [3:0]              hex_d;
    logic [VALUE_BITS-1:0]   acc_base, acc_dec, acc_oct, acc_hex;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign c = s_axis_tdata;

    assign is_dec    = (c >= CH_0) && (c <= CH_9);
    assign is_oct    = (c >= CH_0) && (c <= CH_7);
    assign is_hex_lc = (c >= CH_LA) && (c <= CH_LF);
    assign is_hex_uc = (c >= CH_UA) && (c <= CH_UF);
    assign is_x      = (c == CH_LX) || (c == CH_UX);
    assign hex_d     = is_dec ? c[3:0] : c[3:0] + 4'd9;

    // A literal always starts from zero
    assign acc_base = (phase_reg == PH_START) ? '0 : acc_reg;
    assign acc_dec  = (acc_base << 3) + (acc_base << 1)
                    + {{(VALUE_BITS-4){1'b0}}, c[3:0]};
    assign acc_oct  = {acc_base[VALUE_BITS-4:0], c[2:0]};
    assign acc_hex  = {acc_base[VALUE_BITS-5:0], hex_d};

    always_comb
    begin
        logic push;
        phase_next = phase_reg;
        acc_next   = acc_base;
        sfx_next   = sfx_reg;
        cnt_next   = cnt_reg;
        push       = 1'b0;
        unique case (phase_reg)
            PH_START:
            begin
                if (c == CH_0)
                begin
                    phase_next = PH_ZERO;
                end
                else if (is_dec)
                begin
                    phase_next = PH_DEC;
                    acc_next = acc_dec;
                end
                else
                begin
                    push = 1'b1;
                end
            end
            PH_ZERO:
            begin
                if (is_x)
                begin
                    phase_next = PH_HEX;
                end
                else if (is_oct)
                begin
                    phase_next = PH_OCT;
                    acc_next = acc_oct;
                end
                else
                begin
                    push = 1'b1;
                end
            end
            PH_HEX:
            begin
                if (is_dec || is_hex_lc || is_hex_uc)
                begin
                    acc_next = acc_hex;
                end
                else
                begin
                    push = 1'b1;
                end
            end
            PH_OCT:
            begin
                if (is_oct)
                begin
                    acc_next = acc_oct;
                end
                else
                begin
                    push = 1'b1;
                end
            end
            PH_DEC:
            begin
                if (is_dec)
                begin
                    acc_next = acc_dec;
                end
                else
                begin
                    push = 1'b1;
                end
            end
            default:
            begin
                push = 1'b1;
            end
        endcase

        // Keep the first three suffix characters; saturate the count at too-long
        if (push)
        begin
            phase_next = PH_SUF;
            if (cnt_reg < 3'(SFX_MAX))
            begin
                sfx_next[cnt_reg[1:0]] = c;
            end
            if (cnt_reg < SFX_CNT_TOO_LONG)
            begin
                cnt_next = cnt_reg + 3'd1;
            end
        end

        value_next = OUT_BITS'($signed(acc_next));
        ok_next    = sfx_match(cnt_next, sfx_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            acc_reg       <= '0;
            sfx_reg       <= '0;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            if (accept && s_axis_tlast)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                sfx_reg <= sfx_next;
                if (s_axis_tlast)
                begin
                    // Result out, parser back to start of literal
                    value_reg <= value_next;
                    ok_reg    <= ok_next;
                    phase_reg <= PH_START;
                    acc_reg   <= '0;
                    cnt_reg   <= 3'd0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    acc_reg   <= acc_next;
                    cnt_reg   <= cnt_next;
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = value_reg;
    assign m_axis_tuser  = ok_reg;

endmodule

`default_nettype wire
